FILE: hw/rtl/png_ru_pkg.sv
// shared types, constants and the paeth predictor for the png row unfilter
`timescale 1ns / 1ps

package png_ru_pkg;

  localparam int MAX_ROW_BYTES_DEF   = 4096;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic [7:0] FILT_MAX_CODE = 8'd4;

  localparam logic REG_BPP = 1'b0;
  localparam logic REG_LEN = 1'b1;

  typedef struct packed {
    logic       bad;
    logic       last;
    logic [2:0] filter;
    logic [7:0] data;
  } s1_ctl_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [8:0] pa;
    logic [8:0] pb;
    logic [9:0] pc;
    logic [9:0] ab;
    logic [9:0] c2;
    logic [7:0] pick;
    pa = (b >= c) ? {1'b0, b - c} : {1'b0, c - b};
    pb = (a >= c) ? {1'b0, a - c} : {1'b0, c - a};
    ab = {2'b00, a} + {2'b00, b};
    c2 = {1'b0, c, 1'b0};
    pc = (ab >= c2) ? ab - c2 : c2 - ab;
    if (pa <= pb && {1'b0, pa} <= pc) begin
      pick = a;
    end else if ({1'b0, pb} <= pc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

FILE: hw/rtl/png_ru_row_mem.sv
// prior row byte memory, one write and one registered read port
`timescale 1ns / 1ps

module png_ru_row_mem #(
  parameter int DEPTH = png_ru_pkg::MAX_ROW_BYTES_DEF,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same-cycle write to the read entry is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: hw/rtl/png_ru_ctrl.sv
// row sequencing: filter type capture, column count, error latch, read issue
`timescale 1ns / 1ps

module png_ru_ctrl #(
  parameter int MAX_ROW_BYTES = png_ru_pkg::MAX_ROW_BYTES_DEF,
  parameter int COL_W         = 12,
  parameter int CNT_W         = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,
  input  logic [12:0]          row_bytes,
  input  logic                 s1_adv,
  output logic                 s1_valid,
  output png_ru_pkg::s1_ctl_t  s1_ctl,
  output logic [COL_W-1:0]     s1_col,
  output logic                 rd_en,
  output logic [COL_W-1:0]     rd_addr
);

  logic             awaiting;
  logic             error_latched;
  logic [COL_W-1:0] column_pos;
  logic [2:0]       row_filter;
  logic             accept;
  logic             s1_load;
  logic [CNT_W-1:0] eff_len;
  logic [CNT_W-1:0] col_inc;
  logic             last;

  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;
  assign rd_en    = accept && !error_latched && !awaiting;
  assign rd_addr  = column_pos;
  assign s1_load  = accept && !error_latched &&
                    (!awaiting || s_tdata > png_ru_pkg::FILT_MAX_CODE);

  always_comb begin
    if (row_bytes == 13'd0) begin
      eff_len = CNT_W'(1);
    end else if (32'(row_bytes) > 32'(MAX_ROW_BYTES)) begin
      eff_len = CNT_W'(MAX_ROW_BYTES);
    end else begin
      eff_len = CNT_W'(row_bytes);
    end
  end

  assign col_inc = CNT_W'(column_pos) + CNT_W'(1);
  assign last    = col_inc >= eff_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting      <= 1'b1;
      error_latched <= 1'b0;
      column_pos    <= '0;
      row_filter    <= png_ru_pkg::FILT_NONE;
      s1_valid      <= 1'b0;
    end else begin
      s1_valid <= s1_load || (s1_valid && !s1_adv);
      if (accept && !error_latched) begin
        if (awaiting) begin
          if (s_tdata > png_ru_pkg::FILT_MAX_CODE) begin
            error_latched <= 1'b1;
          end else begin
            row_filter <= s_tdata[2:0];
            awaiting   <= 1'b0;
            column_pos <= '0;
          end
        end else begin
          awaiting   <= last;
          column_pos <= last ? '0 : col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl.bad    <= awaiting;
      s1_ctl.last   <= last && !awaiting;
      s1_ctl.filter <= row_filter;
      s1_ctl.data   <= s_tdata;
      s1_col        <= column_pos;
    end
  end

endmodule

FILE: hw/rtl/png_ru_recon.sv
// byte reconstruction: neighbour rings, predictor, write back and output word
`timescale 1ns / 1ps

module png_ru_recon #(
  parameter int MAX_PIXEL_BYTES = png_ru_pkg::MAX_PIXEL_BYTES_DEF,
  parameter int COL_W           = 12,
  parameter int CNT_W           = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s1_valid,
  input  png_ru_pkg::s1_ctl_t  s1_ctl,
  input  logic [COL_W-1:0]     s1_col,
  output logic                 s1_adv,
  input  logic [7:0]           rd_data,
  input  logic [3:0]           bytes_per_pixel,
  output logic                 wr_en,
  output logic [COL_W-1:0]     wr_addr,
  output logic [7:0]           wr_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  output logic                 m_tuser
);

  localparam int RING_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int RING_D = 2 ** RING_W;

  logic [7:0]        left_ring [RING_D];
  logic [7:0]        upleft_ring [RING_D];
  logic [CNT_W-1:0]  fill;
  logic [3:0]        eff_bpp;
  logic              has_left;
  logic [RING_W-1:0] nb_idx;
  logic [RING_W-1:0] cur_idx;
  logic [7:0]        a;
  logic [7:0]        b;
  logic [7:0]        c;
  logic [8:0]        ab_sum;
  logic [7:0]        pred;
  logic [7:0]        res;

  always_comb begin
    if (bytes_per_pixel == 4'd0) begin
      eff_bpp = 4'd1;
    end else if (32'(bytes_per_pixel) > 32'(MAX_PIXEL_BYTES)) begin
      eff_bpp = 4'(MAX_PIXEL_BYTES);
    end else begin
      eff_bpp = bytes_per_pixel;
    end
  end

  assign has_left = 32'(s1_col) >= 32'(eff_bpp);
  assign cur_idx  = RING_W'(s1_col);
  assign nb_idx   = cur_idx - RING_W'(eff_bpp);

  // entries at or past the fill count were never written since reset
  assign b      = (CNT_W'(s1_col) < fill) ? rd_data : 8'd0;
  assign a      = has_left ? left_ring[nb_idx] : 8'd0;
  assign c      = has_left ? upleft_ring[nb_idx] : 8'd0;
  assign ab_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (s1_ctl.filter)
      png_ru_pkg::FILT_SUB:   pred = a;
      png_ru_pkg::FILT_UP:    pred = b;
      png_ru_pkg::FILT_AVG:   pred = ab_sum[8:1];
      png_ru_pkg::FILT_PAETH: pred = png_ru_pkg::paeth(a, b, c);
      default:                pred = 8'd0;
    endcase
  end

  assign res     = s1_ctl.data + pred;
  assign s1_adv  = s1_valid && (!m_tvalid || m_tready);
  assign wr_en   = s1_adv && !s1_ctl.bad;
  assign wr_addr = s1_col;
  assign wr_data = res;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_ring[cur_idx]   <= res;
      upleft_ring[cur_idx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (wr_en && CNT_W'(s1_col) == fill) begin
        fill <= fill + CNT_W'(1);
      end
      if (s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= s1_ctl.bad ? 8'd0 : res;
      m_tlast <= s1_ctl.last && !s1_ctl.bad;
      m_tuser <= s1_ctl.bad;
    end
  end

endmodule

FILE: hw/rtl/png_row_unfilter_unit.sv
// png row unfilter top level: register port, sequencer, prior row memory, reconstruction
// a data word passes the sequencer's stage register and then the output register before
//   it is offered on the output
// throughput: one word per cycle, type words included, while the output is not stalled;
//   the prior row memory read is registered ahead of the reconstruction stage
// reset: prior row reads as zero via a fill count, no clearing pass; error cleared,
//   bytes_per_pixel and row_bytes set to 1
`timescale 1ns / 1ps

module png_row_unfilter_unit #(
  parameter int MAX_ROW_BYTES   = png_ru_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = png_ru_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // filtered_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // pixel_byte
  output logic        m_tlast,
  output logic        m_tuser    // bad_filter
);

  localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CNT_W = $clog2(MAX_ROW_BYTES + 1);

  logic [3:0]          bytes_per_pixel;
  logic [12:0]         row_bytes;
  logic                cfg_wr;
  logic                s1_valid;
  logic                s1_adv;
  png_ru_pkg::s1_ctl_t s1_ctl;
  logic [COL_W-1:0]    s1_col;
  logic                rd_en;
  logic [COL_W-1:0]    rd_addr;
  logic [7:0]          rd_data;
  logic                wr_en;
  logic [COL_W-1:0]    wr_addr;
  logic [7:0]          wr_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 4'd1;
      row_bytes       <= 13'd1;
    end else if (cfg_wr) begin
      case (paddr[2])
        png_ru_pkg::REG_BPP: bytes_per_pixel <= pwdata[3:0];
        png_ru_pkg::REG_LEN: row_bytes       <= pwdata[12:0];
        default:             row_bytes       <= row_bytes;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      png_ru_pkg::REG_BPP: prdata = {28'd0, bytes_per_pixel};
      png_ru_pkg::REG_LEN: prdata = {19'd0, row_bytes};
      default:             prdata = 32'd0;
    endcase
  end

  png_ru_ctrl #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .COL_W         (COL_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .row_bytes (row_bytes),
    .s1_adv    (s1_adv),
    .s1_valid  (s1_valid),
    .s1_ctl    (s1_ctl),
    .s1_col    (s1_col),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  png_ru_row_mem #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (COL_W)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  png_ru_recon #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .COL_W           (COL_W),
    .CNT_W           (CNT_W)
  ) u_recon (
    .clk             (clk),
    .rst             (rst),
    .s1_valid        (s1_valid),
    .s1_ctl          (s1_ctl),
    .s1_col          (s1_col),
    .s1_adv          (s1_adv),
    .rd_data         (rd_data),
    .bytes_per_pixel (bytes_per_pixel),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .m_tuser         (m_tuser)
  );

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the png row unfilter: apb set-up, random stream words, scoreboard
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } pixel_t;

  class unfilter_scoreboard;
    logic [7:0] prior_mem [png_ru_pkg::MAX_ROW_BYTES_DEF];
    logic [7:0] left_ring [8];
    logic [7:0] above_left_ring [8];
    int         col_pos;
    logic [2:0] filt;
    bit         want_type;
    bit         err_seen;
    logic [3:0] bpp_reg;
    logic [12:0] len_reg;
    pixel_t     expected_pixels[$];
    int         mismatches;
    int         checked;

    function new();
      foreach (prior_mem[i]) prior_mem[i] = 8'h00;
      foreach (left_ring[i]) begin
        left_ring[i] = 8'h00;
        above_left_ring[i] = 8'h00;
      end
      col_pos = 0;
      filt = png_ru_pkg::FILT_NONE;
      want_type = 1'b1;
      err_seen = 1'b0;
      bpp_reg = 4'd1;
      len_reg = 13'd1;
      mismatches = 0;
      checked = 0;
    endfunction

    function bit awaiting();
      return want_type;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void set_reg(logic idx, logic [31:0] v);
      if (idx == png_ru_pkg::REG_BPP) begin
        bpp_reg = v[3:0];
      end else begin
        len_reg = v[12:0];
      end
    endfunction

    function int paeth_pick(int a, int b, int c);
      int p;
      int da;
      int db;
      int dc;
      p = a + b - c;
      da = (p > a) ? p - a : a - p;
      db = (p > b) ? p - b : b - p;
      dc = (p > c) ? p - c : c - p;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
    endfunction

    function void note_byte(logic [7:0] x);
      int eb;
      int el;
      int c;
      int up;
      int lf;
      int ul;
      int pred;
      pixel_t px;
      if (err_seen) return;
      if (want_type) begin
        if (x > png_ru_pkg::FILT_MAX_CODE) begin
          err_seen = 1'b1;
          px.data = 8'h00;
          px.last = 1'b0;
          px.bad = 1'b1;
          expected_pixels.push_back(px);
          return;
        end
        filt = x[2:0];
        want_type = 1'b0;
        col_pos = 0;
        return;
      end
      eb = (bpp_reg == 0) ? 1 :
           (bpp_reg > png_ru_pkg::MAX_PIXEL_BYTES_DEF) ? png_ru_pkg::MAX_PIXEL_BYTES_DEF :
           bpp_reg;
      el = (len_reg == 0) ? 1 :
           (len_reg > png_ru_pkg::MAX_ROW_BYTES_DEF) ? png_ru_pkg::MAX_ROW_BYTES_DEF :
           len_reg;
      c = (col_pos >= png_ru_pkg::MAX_ROW_BYTES_DEF) ?
          png_ru_pkg::MAX_ROW_BYTES_DEF - 1 : col_pos;
      up = prior_mem[c];
      if (c >= eb) begin
        lf = left_ring[(c - eb) & 7];
        ul = above_left_ring[(c - eb) & 7];
      end else begin
        lf = 0;
        ul = 0;
      end
      case (filt)
        png_ru_pkg::FILT_SUB:   pred = lf;
        png_ru_pkg::FILT_UP:    pred = up;
        png_ru_pkg::FILT_AVG:   pred = (lf + up) >> 1;
        png_ru_pkg::FILT_PAETH: pred = paeth_pick(lf, up, ul);
        default:                pred = 0;
      endcase
      px.data = 8'((x + pred) & 8'hFF);
      above_left_ring[c & 7] = 8'(up);
      left_ring[c & 7] = px.data;
      prior_mem[c] = px.data;
      px.last = (c + 1 >= el);
      px.bad = 1'b0;
      if (px.last) begin
        want_type = 1'b1;
        col_pos = 0;
      end else begin
        col_pos = c + 1;
      end
      expected_pixels.push_back(px);
    endfunction

    function void check_pixel(logic [7:0] d, logic l, logic u);
      pixel_t exp_px;
      checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: data %02h last %0b bad %0b", d, l, u);
        return;
      end
      exp_px = expected_pixels.pop_front();
      if (exp_px.data !== d || exp_px.last !== l || exp_px.bad !== u) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at word %0d: expected data %02h last %0b bad %0b, %s",
                   checked, exp_px.data, exp_px.last, exp_px.bad,
                   $sformatf("got data %02h last %0b bad %0b", d, l, u));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  unfilter_scoreboard sb;
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold;
  int n_in;
  int n_writes;
  int phase;

  png_row_unfilter_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),    // filtered_byte
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),    // pixel_byte
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)     // bad_filter
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // output side: sample at rising edge, ready changes at falling edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_pixel(m_tdata, m_tlast, m_tuser);
      rx_hold = rx_idle_on ? $urandom_range(0, 15) : 0;
    end
  end

  initial begin
    m_tready = 1'b0;
    rx_hold = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    n_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] v);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(v);
    n_in++;
    @(negedge clk);
  endtask

  // sender holds off until every expected word is out, then lets the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] next_word();
    int r;
    if (sb.awaiting())
      return {5'b0, 3'($urandom_range(png_ru_pkg::FILT_NONE, png_ru_pkg::FILT_PAETH))};
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_stream(input int count);
    for (int i = 0; i < count; i++) send_byte(next_word());
  endtask

  initial begin
    int nb;
    int r;
    logic [3:0] bpp_v;
    logic [12:0] len_v;
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    n_in = 0;
    n_writes = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults, zero row above
    send_byte({5'b0, png_ru_pkg::FILT_NONE});
    send_byte(8'hFF);
    send_byte({5'b0, png_ru_pkg::FILT_UP});
    send_byte(8'h01);
    drain();
    write_reg(png_ru_pkg::REG_BPP, 32'd2);
    write_reg(png_ru_pkg::REG_LEN, 32'd4);
    send_byte({5'b0, png_ru_pkg::FILT_PAETH});
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    send_byte({5'b0, png_ru_pkg::FILT_AVG});
    repeat (4) send_byte(8'hFF);
    send_byte({5'b0, png_ru_pkg::FILT_SUB});
    send_byte(8'h00);
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    // row length shrinks mid-row, zero values clamp to one
    send_byte({5'b0, png_ru_pkg::FILT_UP});
    send_byte(8'h80);
    send_byte(8'h7F);
    drain();
    write_reg(png_ru_pkg::REG_LEN, 32'd0);
    write_reg(png_ru_pkg::REG_BPP, 32'd0);
    send_byte(8'h55);

    phase = 0;
    while (n_in < 1880) begin
      drain();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 3 || phase == 6) begin
        // wide rows at the widest stride, plain and clamped values
        bpp_v = (phase == 3) ? 4'd8 : 4'd15;
        len_v = (phase == 3) ? 13'd4096 : 13'd8191;
        write_reg(png_ru_pkg::REG_BPP,
                  {16'($urandom_range(0, 16'hFFFF)), 12'h000, bpp_v});
        write_reg(png_ru_pkg::REG_LEN,
                  {16'($urandom_range(0, 16'hFFFF)), 3'b000, len_v});
        send_stream(300);
      end else begin
        r = $urandom_range(0, 9);
        bpp_v = (r == 0) ? 4'd0 :
                (r == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
        r = $urandom_range(0, 9);
        len_v = (r == 0) ? 13'd0 : (r == 1) ? 13'd1 : 13'($urandom_range(1, 24));
        write_reg(png_ru_pkg::REG_BPP,
                  {16'($urandom_range(0, 16'hFFFF)), 12'h000, bpp_v});
        write_reg(png_ru_pkg::REG_LEN,
                  {16'($urandom_range(0, 16'hFFFF)), 3'b000, len_v});
        nb = $urandom_range(5, 60);
        send_stream(nb);
      end
      phase++;
    end

    // bad filter type latches the error, later words are dropped
    drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    while (!sb.awaiting()) send_byte(next_word());
    send_byte(8'($urandom_range(5, 255)));
    repeat (12) send_byte(8'($urandom_range(0, 255)));

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("run: %0d input words, %0d output words, %0d register writes over %0d phases",
             n_in, sb.checked, n_writes, phase);
    $display("run: all filter types, strides, short rows and partial full-width rows, %s",
             "mid-row changes, bad type");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d words still expected", sb.mismatches, sb.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/png_ru_pkg.sv
hw/rtl/png_ru_row_mem.sv
hw/rtl/png_ru_ctrl.sv
hw/rtl/png_ru_recon.sv
hw/rtl/png_row_unfilter_unit.sv
sim/testbench.sv
